>>> design/rhbp_pkg.sv
// Shared types, codes and constants for the RESP header and bulk-string parser.
package rhbp_pkg;

    // Length accumulator width: default, and the fixed width of the length port.
    localparam int LEN_BITS_DFLT = 32;
    localparam int LEN_OUT_W     = 32;

    // Configuration register indexes and reset values.
    localparam logic CFG_ARRAY_CODE = 1'b0;
    localparam logic CFG_BULK_CODE  = 1'b1;
    localparam logic [7:0] ARRAY_CODE_RST = 8'd42;  // '*'
    localparam logic [7:0] BULK_CODE_RST  = 8'd36;  // '$'

    // Framing characters.
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;

    // Result status codes.
    localparam logic [2:0] ST_PENDING  = 3'd0;
    localparam logic [2:0] ST_COUNT    = 3'd1;
    localparam logic [2:0] ST_LENGTH   = 3'd2;
    localparam logic [2:0] ST_PAYLOAD  = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;
    localparam logic [2:0] ST_ERROR    = 3'd5;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_DIGITS  = 6'b000010,
        PH_HDR_LF  = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_END_CR  = 6'b010000,
        PH_END_LF  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       func;
    } rhbp_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [LEN_OUT_W-1:0] length_value;
        logic [7:0]           payload_byte;
    } rhbp_result_t;

endpackage

>>> design/rhbp_fsm.sv
// Parser state machine: header checks, decimal length accumulation, payload count.
module rhbp_fsm #(
    parameter int LEN_BITS = rhbp_pkg::LEN_BITS_DFLT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  rhbp_pkg::rhbp_item_t  item,
    input  logic [7:0]            array_code,
    input  logic [7:0]            bulk_code,
    output rhbp_pkg::rhbp_result_t result
);
    import rhbp_pkg::*;

    localparam int SUM_W = LEN_BITS + 4;

    phase_t              phase_reg, phase_next;
    logic                expect_bulk_reg, expect_bulk_next;
    logic [LEN_BITS-1:0] acc_reg, acc_next;
    logic                digit_seen_reg, digit_seen_next;
    logic [LEN_BITS-1:0] remain_reg, remain_next;

    logic [SUM_W-1:0]    acc_ext;
    logic [SUM_W-1:0]    acc_sum;
    logic                acc_ovf;
    logic                is_digit;
    logic [LEN_BITS-1:0] remain_dec;

    // acc * 10 + digit, with four guard bits to catch overflow
    assign acc_ext  = {4'b0000, acc_reg};
    assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + {{LEN_BITS{1'b0}}, item.data_byte[3:0]};
    assign acc_ovf  = |acc_sum[SUM_W-1:LEN_BITS];
    assign is_digit = item.data_byte inside {[CH_ZERO:CH_NINE]};
    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        expect_bulk_next = expect_bulk_reg;
        acc_next         = acc_reg;
        digit_seen_next  = digit_seen_reg;
        remain_next      = remain_reg;
        result.status       = ST_PENDING;
        result.length_value = '0;
        result.payload_byte = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                expect_bulk_next = item.func;
                if (item.data_byte == (item.func ? bulk_code : array_code))
                begin
                    phase_next      = PH_DIGITS;
                    acc_next        = '0;
                    digit_seen_next = 1'b0;
                end
                else
                begin
                    result.status = ST_ERROR;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    if (acc_ovf)
                    begin
                        result.status = ST_ERROR;
                        phase_next    = PH_IDLE;
                    end
                    else
                    begin
                        acc_next        = acc_sum[LEN_BITS-1:0];
                        digit_seen_next = 1'b1;
                    end
                end
                else if (item.data_byte == CH_CR && digit_seen_reg)
                begin
                    phase_next = PH_HDR_LF;
                end
                else
                begin
                    result.status = ST_ERROR;
                    phase_next    = PH_IDLE;
                end
            end
            PH_HDR_LF:
            begin
                if (item.data_byte != CH_LF)
                begin
                    result.status = ST_ERROR;
                    phase_next    = PH_IDLE;
                end
                else if (expect_bulk_reg)
                begin
                    result.status       = ST_LENGTH;
                    result.length_value = LEN_OUT_W'(acc_reg);
                    remain_next         = acc_reg;
                    phase_next          = (acc_reg == '0) ? PH_END_CR : PH_PAYLOAD;
                end
                else
                begin
                    result.status       = ST_COUNT;
                    result.length_value = LEN_OUT_W'(acc_reg);
                    phase_next          = PH_IDLE;
                end
            end
            PH_PAYLOAD:
            begin
                result.status       = ST_PAYLOAD;
                result.payload_byte = item.data_byte;
                remain_next         = remain_dec;
                if (remain_dec == '0)
                begin
                    phase_next = PH_END_CR;
                end
            end
            PH_END_CR:
            begin
                if (item.data_byte == CH_CR)
                begin
                    phase_next = PH_END_LF;
                end
                else
                begin
                    result.status = ST_ERROR;
                    phase_next    = PH_IDLE;
                end
            end
            PH_END_LF:
            begin
                result.status = (item.data_byte == CH_LF) ? ST_COMPLETE : ST_ERROR;
                phase_next    = PH_IDLE;
            end
            default:
            begin
                result.status = ST_ERROR;
                phase_next    = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            expect_bulk_reg <= 1'b0;
            acc_reg         <= '0;
            digit_seen_reg  <= 1'b0;
            remain_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            expect_bulk_reg <= expect_bulk_next;
            acc_reg         <= acc_next;
            digit_seen_reg  <= digit_seen_next;
            remain_reg      <= remain_next;
        end
    end

`ifndef ASSERT_OFF
    // payload phase always has bytes left to pass
    a_payload_remain: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with zero bytes remaining");

    // header CR is only taken after at least one digit
    a_hdr_digit: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HDR_LF |-> digit_seen_reg)
        else $error("header LF phase without a digit");

    // a bulk length result always lands in payload or closing CR phase
    a_len_next: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.status == ST_LENGTH |=> phase_reg == PH_PAYLOAD || phase_reg == PH_END_CR)
        else $error("bad phase after bulk length");
`endif

endmodule

>>> design/resp_header_and_bulk_parser.sv
// Top level of the RESP array-header and bulk-string parser, one byte per transfer.
// A byte waits in the input stage until the parser steps and registers its result.
// One byte per cycle unless rsp_ready stalls; the only loop is the state update.
// Reset (rst_n low, async): parser idle awaiting a type byte, both stages empty,
// type codes back to '*' (array) and '$' (bulk).
module resp_header_and_bulk_parser #(
    parameter int LEN_BITS = rhbp_pkg::LEN_BITS_DFLT
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel: one stream byte per transfer
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [7:0]  data_byte,
    input  logic        func,
    // response channel: one status per byte
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  status,
    output logic [rhbp_pkg::LEN_OUT_W-1:0] length_value,
    output logic [7:0]  payload_byte,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import rhbp_pkg::*;

    logic [7:0]   array_code_reg;
    logic [7:0]   bulk_code_reg;

    // Input stage: holds one accepted byte until the parser steps on it.
    logic         s1_valid_reg;
    rhbp_item_t   s1_item_reg;
    logic         advance;

    // Result stage.
    logic         rsp_valid_reg;
    rhbp_result_t rsp_reg;
    rhbp_result_t step_result;

    // The parser steps when the input stage is full and the result register
    // is free or being drained this cycle.
    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_code_reg <= ARRAY_CODE_RST;
            bulk_code_reg  <= BULK_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ARRAY_CODE: array_code_reg <= cfg_data;
                CFG_BULK_CODE:  bulk_code_reg  <= cfg_data;
                default:        array_code_reg <= array_code_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_item_reg.data_byte <= data_byte;
            s1_item_reg.func      <= func;
        end
    end

    rhbp_fsm #(
        .LEN_BITS (LEN_BITS)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (s1_item_reg),
        .array_code (array_code_reg),
        .bulk_code  (bulk_code_reg),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= step_result;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_reg.status;
    assign length_value = rsp_reg.length_value;
    assign payload_byte = rsp_reg.payload_byte;

`ifndef ASSERT_OFF
    // length is only reported with a count or length status
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_COUNT && status != ST_LENGTH |-> length_value == '0)
        else $error("length_value set with wrong status");

    // payload byte is only reported with a payload status
    a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_PAYLOAD |-> payload_byte == '0)
        else $error("payload_byte set with wrong status");

    // a stalled input stage keeps its byte until the parser steps
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input stage lost a byte");

    // a byte that steps the parser always yields a registered result
    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("parser step without a result");
`endif

endmodule

>>> verif/resp_header_and_bulk_parser_test.sv
// Self-checking testbench for the RESP array-header and bulk-string parser.
`timescale 1ns / 1ps

module resp_header_and_bulk_parser_test;

    import rhbp_pkg::*;

    localparam int LEN_BITS        = LEN_BITS_DFLT;
    localparam int RESULT_LATENCY  = 1;     // part of the settle margin in drain()
    localparam int NUM_PHASES      = 6;     // register settings the run walks through
    localparam int ITEMS_PER_PHASE = 265;
    localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no transfer on either channel
    localparam int MAX_REPORTS     = 200;   // keep the log readable on a badly broken build

    // ------------------------------------------------------------------
    // Status predictor plus the queue of statuses still awaited from the block.
    // take_byte() runs on every request transfer, check_status() on every
    // response transfer.
    // ------------------------------------------------------------------
    class resp_parse_scoreboard;
        phase_t       parse_phase;
        bit           expect_bulk;
        logic [31:0]  len_acc;
        bit           digit_seen;
        logic [31:0]  bytes_left;
        logic [7:0]   array_code;
        logic [7:0]   bulk_code;
        rhbp_result_t awaited[$];
        int           errors;
        int           results_seen;

        function new();
            parse_phase  = PH_IDLE;
            expect_bulk  = 1'b0;
            len_acc      = '0;
            digit_seen   = 1'b0;
            bytes_left   = '0;
            array_code   = ARRAY_CODE_RST;
            bulk_code    = BULK_CODE_RST;
            errors       = 0;
            results_seen = 0;
        endfunction

        task report_mismatch(input string msg);
            if (errors < MAX_REPORTS)
                $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
            errors++;
        endtask

        // One parser step per accepted byte; exactly one status comes out of it.
        function void take_byte(input logic [7:0] b, input logic f);
            rhbp_result_t    r;
            longint unsigned nxt;
            longint unsigned limit;
            limit = (64'd1 << LEN_BITS) - 64'd1;
            r = '0;
            r.status = ST_PENDING;
            case (parse_phase)
                PH_IDLE:
                begin
                    // func only matters on the type byte
                    expect_bulk = f;
                    if (b == (f ? bulk_code : array_code))
                    begin
                        parse_phase = PH_DIGITS;
                        len_acc     = '0;
                        digit_seen  = 1'b0;
                    end
                    else
                        r.status = ST_ERROR;   // wrong type byte, stay idle
                end
                PH_DIGITS:
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        nxt = {32'd0, len_acc} * 64'd10 + {56'd0, b} - {56'd0, CH_ZERO};
                        if (nxt > limit)
                        begin
                            r.status    = ST_ERROR;   // overflow flagged on this digit
                            parse_phase = PH_IDLE;
                        end
                        else
                        begin
                            len_acc    = nxt[31:0];
                            digit_seen = 1'b1;
                        end
                    end
                    else if (b == CH_CR && digit_seen)
                        parse_phase = PH_HDR_LF;
                    else
                    begin
                        r.status    = ST_ERROR;       // stray byte or CR with no digits
                        parse_phase = PH_IDLE;
                    end
                end
                PH_HDR_LF:
                begin
                    if (b != CH_LF)
                    begin
                        r.status    = ST_ERROR;
                        parse_phase = PH_IDLE;
                    end
                    else if (expect_bulk)
                    begin
                        r.status       = ST_LENGTH;
                        r.length_value = len_acc;
                        bytes_left     = len_acc;
                        parse_phase    = (len_acc == 0) ? PH_END_CR : PH_PAYLOAD;
                    end
                    else
                    begin
                        r.status       = ST_COUNT;
                        r.length_value = len_acc;
                        parse_phase    = PH_IDLE;
                    end
                end
                PH_PAYLOAD:
                begin
                    r.status       = ST_PAYLOAD;
                    r.payload_byte = b;
                    if (bytes_left != 0)
                        bytes_left = bytes_left - 32'd1;
                    if (bytes_left == 0)
                        parse_phase = PH_END_CR;
                end
                PH_END_CR:
                begin
                    if (b == CH_CR)
                        parse_phase = PH_END_LF;
                    else
                    begin
                        r.status    = ST_ERROR;
                        parse_phase = PH_IDLE;
                    end
                end
                PH_END_LF:
                begin
                    r.status    = (b == CH_LF) ? ST_COMPLETE : ST_ERROR;
                    parse_phase = PH_IDLE;
                end
                default:
                begin
                    r.status    = ST_ERROR;
                    parse_phase = PH_IDLE;
                end
            endcase
            awaited.push_back(r);
        endfunction

        task check_status(input logic [2:0] st, input logic [31:0] lv, input logic [7:0] pb);
            rhbp_result_t w;
            if (awaited.size() == 0)
                report_mismatch($sformatf("unexpected status %0d", st));
            else
            begin
                w = awaited.pop_front();
                if (st !== w.status)
                    report_mismatch($sformatf("status %0d, want %0d", st, w.status));
                if (lv !== w.length_value)
                    report_mismatch($sformatf("length_value %0d, want %0d",
                                              lv, w.length_value));
                if (pb !== w.payload_byte)
                    report_mismatch($sformatf("payload_byte 0x%02h, want 0x%02h",
                                              pb, w.payload_byte));
            end
            results_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // Block inputs: all known from time zero.
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        func      = 1'b0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [2:0]  status;
    logic [LEN_OUT_W-1:0] length_value;
    logic [7:0]  payload_byte;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data  = 8'd0;

    resp_parse_scoreboard sb = new();

    int bytes_sent  = 0;
    int idle_cycles = 0;
    bit burst       = 1'b0;   // set for a sequence: no request gaps at all

    resp_header_and_bulk_parser #(
        .LEN_BITS(LEN_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .data_byte   (data_byte),
        .func        (func),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .length_value(length_value),
        .payload_byte(payload_byte),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Response monitor: every transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
            sb.check_status(status, length_value, payload_byte);
    end

    // Watchdog: a run with no transfer for too long is a hang.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Mostly zero, often short, now and then long.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        else if (sel < 90)
            return $urandom_range(1, 3);
        else if (sel < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Receiver throttle: runs of ready broken by stalls; some runs are long
    // so the block also sees stretches of no back-pressure at all.
    initial
    begin : rsp_throttle
        int on_len;
        int off_len;
        @(posedge rst_n);
        forever
        begin
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 4);
            @(negedge clk);
            rsp_ready <= 1'b1;
            repeat (on_len - 1) @(negedge clk);
            off_len = pick_gap();
            if (off_len > 0)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
                repeat (off_len - 1) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side. send_byte() leaves valid high after the transfer so
    // back-to-back bytes never see valid drop; release_stream() lowers it.
    // ------------------------------------------------------------------
    task automatic send_byte(input rhbp_item_t it);
        int gap;
        gap = burst ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        data_byte <= it.data_byte;
        func      <= it.func;
        do @(posedge clk); while (!req_ready);
        sb.take_byte(it.data_byte, it.func);
        bytes_sent++;
    endtask

    task automatic release_stream();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    // Wait for every awaited status, then let the pipeline settle.
    task automatic drain();
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    // Both type-code registers, back to back; block must be idle.
    task automatic write_codes(input logic [7:0] arr, input logic [7:0] blk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ARRAY_CODE;
        cfg_data  <= arr;
        @(negedge clk);
        cfg_index <= CFG_BULK_CODE;
        cfg_data  <= blk;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.array_code = arr;
        sb.bulk_code  = blk;
    endtask

    // Random type code that is not a digit or a framing byte, so a truncated
    // header is never silently continued by the next type byte.
    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic void push_item(ref rhbp_item_t q[$], input logic [7:0] b,
                                      input logic f);
        rhbp_item_t it;
        it.data_byte = b;
        it.func      = f;
        q.push_back(it);
    endfunction

    // Decimal digits of v, optionally after leading zeros; func is don't-care here.
    function automatic void push_decimal(ref rhbp_item_t q[$], input longint unsigned v,
                                         input int zeros);
        logic [7:0] digs[$];
        repeat (zeros) push_item(q, CH_ZERO, 1'($urandom_range(0, 1)));
        do
        begin
            digs.push_front(CH_ZERO + 8'(v % 64'd10));
            v = v / 64'd10;
        end
        while (v != 0);
        foreach (digs[i])
            push_item(q, digs[i], 1'($urandom_range(0, 1)));
    endfunction

    // Payload bytes lean toward the characters the parser reacts to elsewhere.
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 9))
            0:       return CH_CR;
            1:       return CH_LF;
            2:       return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One well-formed element with random content; bulk strings carry their
    // payload only when the length is small enough to send.
    function automatic void build_element(ref rhbp_item_t q[$]);
        logic            f;
        longint unsigned n;
        int              sel;
        int              zeros;
        f   = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (f)
        begin
            if (sel < 85)
                n = $urandom_range(0, 12);
            else if (sel < 95)
                n = $urandom_range(13, 40);
            else
                n = 64'd4294967296 + $urandom_range(0, 1000);   // overflows
        end
        else
        begin
            if (sel < 60)
                n = $urandom_range(0, 9);
            else if (sel < 80)
                n = $urandom;
            else if (sel < 88)
                n = 64'hFFFF_FFFF;                              // largest legal count
            else if (sel < 96)
                n = 64'd4294967296 + $urandom;                  // past the top
            else
                n = 64'd99999999999;
        end
        zeros = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        push_item(q, f ? sb.bulk_code : sb.array_code, f);
        push_decimal(q, n, zeros);
        push_item(q, CH_CR, 1'($urandom_range(0, 1)));
        push_item(q, CH_LF, 1'($urandom_range(0, 1)));
        if (f && n <= 40)
        begin
            repeat (n) push_item(q, pick_payload(), 1'($urandom_range(0, 1)));
            push_item(q, CH_CR, 1'($urandom_range(0, 1)));
            push_item(q, CH_LF, 1'($urandom_range(0, 1)));
        end
    endfunction

    // Random element, sometimes broken, sometimes followed by noise.
    function automatic void build_sequence(ref rhbp_item_t q[$]);
        int kind;
        int k;
        q.delete();
        build_element(q);
        kind = $urandom_range(0, 99);
        k    = $urandom_range(0, q.size() - 1);
        if (kind < 8)
            q[k].data_byte = 8'($urandom_range(0, 255));
        else if (kind < 14 && k > 0)
            q = q[0:k-1];                        // element cut short
        else if (kind < 19)
            q.delete(k);                         // one byte lost
        else if (kind < 23)
            q[0].func = ~q[0].func;              // other element kind expected
        if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 4))
                push_item(q, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    // Directed opening: error paths other than overflow and a bad closing LF, an array count,
    // an empty bulk string, and the byte extremes, all with the reset type codes.
    task automatic run_directed();
        rhbp_item_t q[$];
        // wrong type byte
        push_item(q, 8'h00, 1'b0);
        // CR with no digits
        push_item(q, ARRAY_CODE_RST, 1'b0);
        push_item(q, CH_CR, 1'b1);
        // non-digit inside the header
        push_item(q, BULK_CODE_RST, 1'b1);
        push_item(q, CH_ZERO + 8'd9, 1'b0);
        push_item(q, 8'hFF, 1'b1);
        // CR not followed by LF
        push_item(q, ARRAY_CODE_RST, 1'b0);
        push_item(q, CH_ZERO, 1'b1);
        push_item(q, CH_CR, 1'b0);
        push_item(q, "X", 1'b1);
        // array count of zero
        push_item(q, ARRAY_CODE_RST, 1'b0);
        push_item(q, CH_ZERO, 1'b0);
        push_item(q, CH_CR, 1'b1);
        push_item(q, CH_LF, 1'b0);
        // zero-length bulk string goes straight to the closing CR LF
        push_item(q, BULK_CODE_RST, 1'b1);
        push_item(q, CH_ZERO, 1'b0);
        push_item(q, CH_CR, 1'b1);
        push_item(q, CH_LF, 1'b0);
        push_item(q, CH_CR, 1'b1);
        push_item(q, CH_LF, 1'b0);
        // closing CR missing after the payload
        push_item(q, BULK_CODE_RST, 1'b1);
        push_item(q, CH_ZERO + 8'd1, 1'b1);
        push_item(q, CH_CR, 1'b0);
        push_item(q, CH_LF, 1'b1);
        push_item(q, 8'hFF, 1'b0);
        push_item(q, "Q", 1'b1);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed bytes, then one random stretch per
    // register setting; codes change only with the block drained.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rhbp_item_t seq[$];
        int         budget;
        logic [7:0] c;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                release_stream();
                drain();
                case (p)
                    1:       write_codes(8'h00, 8'hFF);
                    2:       write_codes(8'hFF, 8'h00);
                    3:       write_codes(pick_code(), pick_code());
                    4:
                    begin
                        // same code for both: func no longer decides acceptance
                        c = pick_code();
                        write_codes(c, c);
                    end
                    default: write_codes(ARRAY_CODE_RST, BULK_CODE_RST);
                endcase
            end
            budget = bytes_sent + ITEMS_PER_PHASE;
            while (bytes_sent < budget)
            begin
                build_sequence(seq);
                burst = ($urandom_range(0, 4) == 0);
                foreach (seq[i])
                    send_byte(seq[i]);
            end
        end

        release_stream();
        drain();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
